// ===== sv/sti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int CFG_W       = 7;

   // datapath widths
   localparam int VAL_W     = 32;
   localparam int OUT_W     = 31;
   localparam int PROD_W    = 2 * VAL_W;
   localparam int DIV_STEPS = PROD_W / 2;            // two quotient bits per cycle
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int QCAP_BIT  = 40;                    // quotient magnitude capped at 2^40
   localparam int SUM_W     = QCAP_BIT + 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(TABLE_DEPTH);

   typedef struct packed {
      logic signed [VAL_W-1:0] k;
      logic signed [VAL_W-1:0] e;
      logic signed [VAL_W-1:0] v;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [VAL_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== sv/spectrum_table_interpolator_top.sv =====
// Piecewise-linear interpolator over a 64-entry breakpoint table, Q16.16.
//
// Input channel (req_*): a transaction moves on a rising edge with req_valid
// high and req_stall low. req_op selects a load (writes one table entry, no
// response) or a query (one response on rsp_*).
// Response channel (rsp_*): a transaction moves with rsp_valid high and
// rsp_stall low; energy and variance are clamped to [0, 2^31-1], table_error
// flags a zero-width segment (values then read 0).
// csr_wr_en/csr_wr_data set active_entries (reset 64); write only when idle.
//
// Throughput: loads go back to back, one per cycle, while no query is in
// progress. A query holds the input side until its response enters the
// output register; the linear search stops at the first entry above x or
// at the last active entry (count clamped to [2, 64]). A table error skips
// the divide. The search reads one entry per cycle; the two dividers run
// side by side (2 bits/cycle). Reset clears control state and sets
// active_entries to 64; table contents are left undefined until loaded.
// A stalled response sits in the output register while the block keeps
// taking loads and works on the next query; that query finishes only once
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_table_interpolator_top import sti_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_op,
   input  wire logic [5:0]              req_entry_index,
   input  wire logic signed [31:0]      req_wavenumber,
   input  wire logic signed [31:0]      req_energy_value,
   input  wire logic signed [31:0]      req_variance_value,

   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [30:0]                  rsp_energy,
   output logic [30:0]                  rsp_variance,
   output logic                         rsp_table_error,

   input  wire logic                    csr_wr_en,
   input  wire logic [6:0]              csr_wr_data
);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_RD_A   = 4'd2;
   localparam logic [3:0] S_RD_B   = 4'd3;
   localparam logic [3:0] S_CAP_B  = 4'd4;
   localparam logic [3:0] S_PREP   = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_DSTART = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0] state_ff, state_in;

   // config
   logic [CFG_W-1:0] active_ff;
   logic [CNT_W-1:0] n_clamped;

   // table memory, one read port (registered), one write port
   entry_type        mem [0:TABLE_DEPTH-1];
   entry_type        rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   entry_type        wr_entry;

   logic req_accept;

   // search
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        chk_ff, chk_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]        a_ff, a_in;
   logic [IDX_W-1:0]        b_ff, b_in;
   logic                    pb_ff, pb_in;          // pivot is the upper entry
   logic [CNT_W-1:0]        n_m1, n_m2, chk_m1;
   logic                    issue;

   // segment data
   entry_type               ent_a_ff, ent_b_ff, ent_p;
   logic [VAL_W:0]          d33, dx33, de33, dv33;
   logic [VAL_W-1:0]        mag_d_ff, mag_dx_ff, mag_de_ff, mag_dv_ff;
   logic                    neg_e_ff, neg_v_ff;
   logic signed [VAL_W-1:0] yp_e_ff, yp_v_ff;
   logic                    err_ff;
   logic [PROD_W-1:0]       prod_e_ff, prod_v_ff;

   // dividers
   div_req_type div_req_e, div_req_v;
   div_rsp_type div_rsp_e, div_rsp_v;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_energy_ff, rsp_variance_ff;
   logic             rsp_err_ff;
   logic             out_load;
   logic [OUT_W-1:0] res_e, res_v;

   function automatic logic [VAL_W-1:0] mag33(input logic [VAL_W:0] v);
      logic [VAL_W:0] nv;
      nv = -v;
      return v[VAL_W] ? nv[VAL_W-1:0] : v[VAL_W-1:0];
   endfunction

   // pivot value plus signed, capped quotient, clamped to [0, 2^31-1]
   function automatic logic [OUT_W-1:0] line_result(input logic [PROD_W-1:0]     quo,
                                                    input logic                  neg,
                                                    input logic signed [VAL_W-1:0] yp);
      logic [QCAP_BIT:0] qs;
      logic [SUM_W-1:0]  qx;
      logic [SUM_W-1:0]  yx;
      logic [SUM_W-1:0]  r;
      logic [OUT_W-1:0]  res;
      if (quo[PROD_W-1:QCAP_BIT] != '0) begin
         qs = {1'b1, {QCAP_BIT{1'b0}}};
      end else begin
         qs = {1'b0, quo[QCAP_BIT-1:0]};
      end
      qx = {1'b0, qs};
      if (neg) begin
         qx = -qx;
      end
      yx = {{(SUM_W-VAL_W){yp[VAL_W-1]}}, yp};
      r  = yx + qx;
      if (r[SUM_W-1]) begin
         res = '0;
      end else if (r[SUM_W-2:OUT_W] != '0) begin
         res = '1;
      end else begin
         res = r[OUT_W-1:0];
      end
      return res;
   endfunction

   // out-of-range active counts fold to [2, TABLE_DEPTH]
   always_comb begin
      if (active_ff < CFG_W'(2)) begin
         n_clamped = CNT_W'(2);
      end else if (active_ff > CFG_W'(TABLE_DEPTH)) begin
         n_clamped = CNT_W'(TABLE_DEPTH);
      end else begin
         n_clamped = CNT_W'(active_ff);
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign mem_we     = req_accept && (req_op == OP_LOAD);
   assign wr_entry.k = req_wavenumber;
   assign wr_entry.e = req_energy_value;
   assign wr_entry.v = req_variance_value;

   assign n_m1   = n_ff - 1'b1;
   assign n_m2   = n_ff - 2'd2;
   assign chk_m1 = chk_ff - 1'b1;
   assign issue  = (cnt_ff < n_ff);

   assign ent_p = pb_ff ? ent_b_ff : ent_a_ff;
   assign d33   = {ent_b_ff.k[VAL_W-1], ent_b_ff.k} - {ent_a_ff.k[VAL_W-1], ent_a_ff.k};
   assign dx33  = {ent_p.k[VAL_W-1], ent_p.k} - {x_ff[VAL_W-1], x_ff};
   assign de33  = {ent_a_ff.e[VAL_W-1], ent_a_ff.e} - {ent_b_ff.e[VAL_W-1], ent_b_ff.e};
   assign dv33  = {ent_a_ff.v[VAL_W-1], ent_a_ff.v} - {ent_b_ff.v[VAL_W-1], ent_b_ff.v};

   assign res_e = line_result(div_rsp_e.quotient, neg_e_ff, yp_e_ff);
   assign res_v = line_result(div_rsp_v.quotient, neg_v_ff, yp_v_ff);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      n_in       = n_ff;
      cnt_in     = cnt_ff;
      chk_in     = chk_ff;
      rd_pend_in = 1'b0;
      a_in       = a_ff;
      b_in       = b_ff;
      pb_in      = pb_ff;
      rd_addr    = cnt_ff[IDX_W-1:0];
      out_load   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_op == OP_QUERY)) begin
               x_in     = req_wavenumber;
               n_in     = n_clamped;
               cnt_in   = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // read one entry ahead, compare the one that just came back
            rd_addr    = cnt_ff[IDX_W-1:0];
            rd_pend_in = issue;
            chk_in     = cnt_ff;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               if (x_ff < rd_data_ff.k) begin
                  rd_pend_in = 1'b0;
                  state_in   = S_RD_A;
                  if (chk_ff == '0) begin
                     a_in  = '0;
                     b_in  = IDX_W'(1);
                     pb_in = 1'b0;
                  end else begin
                     a_in  = chk_m1[IDX_W-1:0];
                     b_in  = chk_ff[IDX_W-1:0];
                     pb_in = 1'b1;
                  end
               end else if (chk_ff == n_m1) begin
                  // nothing exceeds x: extrapolate from the last segment
                  rd_pend_in = 1'b0;
                  state_in   = S_RD_A;
                  a_in       = n_m2[IDX_W-1:0];
                  b_in       = n_m1[IDX_W-1:0];
                  pb_in      = 1'b1;
               end
            end
         end
         S_RD_A: begin
            rd_addr  = a_ff;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            rd_addr  = b_ff;
            state_in = S_CAP_B;
         end
         S_CAP_B: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            state_in = (d33 == '0) ? S_OUT : S_MUL;
         end
         S_MUL: begin
            state_in = S_DSTART;
         end
         S_DSTART: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp_e.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // dividers share the segment width as divisor
   always_comb begin
      div_req_e.start    = (state_ff == S_DSTART);
      div_req_e.dividend = prod_e_ff;
      div_req_e.divisor  = mag_d_ff;
      div_req_v.start    = (state_ff == S_DSTART);
      div_req_v.dividend = prod_v_ff;
      div_req_v.divisor  = mag_d_ff;
   end

   sti_div u_div_energy (
      .clock (clock),
      .reset (reset),
      .req   (div_req_e),
      .rsp   (div_rsp_e)
   );

   sti_div u_div_variance (
      .clock (clock),
      .reset (reset),
      .req   (div_req_v),
      .rsp   (div_rsp_v)
   );

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_entry_index[IDX_W-1:0]] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= ACTIVE_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      n_ff   <= n_in;
      cnt_ff <= cnt_in;
      chk_ff <= chk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      pb_ff  <= pb_in;

      if (state_ff == S_RD_B) begin
         ent_a_ff <= rd_data_ff;
      end
      if (state_ff == S_CAP_B) begin
         ent_b_ff <= rd_data_ff;
      end
      if (state_ff == S_PREP) begin
         mag_d_ff  <= mag33(d33);
         mag_dx_ff <= mag33(dx33);
         mag_de_ff <= mag33(de33);
         mag_dv_ff <= mag33(dv33);
         neg_e_ff  <= de33[VAL_W] ^ dx33[VAL_W] ^ d33[VAL_W];
         neg_v_ff  <= dv33[VAL_W] ^ dx33[VAL_W] ^ d33[VAL_W];
         yp_e_ff   <= ent_p.e;
         yp_v_ff   <= ent_p.v;
         err_ff    <= (d33 == '0);
      end
      if (state_ff == S_MUL) begin
         prod_e_ff <= mag_de_ff * mag_dx_ff;
         prod_v_ff <= mag_dv_ff * mag_dx_ff;
      end
      if (out_load) begin
         rsp_err_ff      <= err_ff;
         rsp_energy_ff   <= err_ff ? '0 : res_e;
         rsp_variance_ff <= err_ff ? '0 : res_v;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_energy      = rsp_energy_ff;
   assign rsp_variance    = rsp_variance_ff;
   assign rsp_table_error = rsp_err_ff;

   // the two dividers run in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_rsp_e.done == div_rsp_v.done)
      else $error("energy and variance dividers out of step");

   // a divider finishes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp_e.done |-> (state_ff == S_DIV))
      else $error("divider done outside of divide state");

   // the search never compares past the active entries
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SEARCH) && rd_pend_ff) |-> (chk_ff < n_ff))
      else $error("search ran past active entries");

   // an error transaction carries zero values
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> ((rsp_energy_ff == '0) && (rsp_variance_ff == '0)))
      else $error("table error response with nonzero values");

endmodule

`default_nettype wire

// ===== sv/sti_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Unsigned 64 / 32 restoring divider, two quotient bits per cycle.
// Divisor must be nonzero. Quotient holds after done until the next start.
module sti_div import sti_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic [VAL_W-1:0]     den_ff;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [VAL_W-1:0]     rem_mid, rem_step;
   logic                 bit_hi, bit_lo;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [VAL_W:0] div_step(input logic [VAL_W-1:0] rem,
                                              input logic             nbit,
                                              input logic [VAL_W-1:0] den);
      logic [VAL_W:0] trial;
      logic [VAL_W:0] diff;
      logic [VAL_W:0] res;
      trial = {rem, nbit};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         res = {1'b1, diff[VAL_W-1:0]};
      end else begin
         res = {1'b0, trial[VAL_W-1:0]};
      end
      return res;
   endfunction

   always_comb begin
      {bit_hi, rem_mid}  = div_step(rem_ff, quo_ff[PROD_W-1], den_ff);
      {bit_lo, rem_step} = div_step(rem_mid, quo_ff[PROD_W-2], den_ff);

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = {quo_ff[PROD_W-3:0], bit_hi, bit_lo};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (req.start) begin
         den_ff <= req.divisor;
      end
   end

   always_comb begin
      rsp.done     = done_ff;
      rsp.quotient = quo_ff;
   end

endmodule

`default_nettype wire

// ===== tb/sv/spectrum_table_interpolator_top_test.sv =====
`timescale 1ns / 1ps

module spectrum_table_interpolator_top_test;
   import sti_pkg::*;

   // Clock, reset and the block's ports. Every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_LOAD;
   logic [5:0]  req_entry_index = '0;
   logic signed [31:0] req_wavenumber = '0;
   logic signed [31:0] req_energy_value = '0;
   logic signed [31:0] req_variance_value = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [30:0] rsp_energy;
   logic [30:0] rsp_variance;
   logic        rsp_table_error;

   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   // One request transaction: a table load or a query.
   typedef struct packed {
      logic              op;
      logic [5:0]        entry_index;
      logic signed [31:0] wavenumber;
      logic signed [31:0] energy_value;
      logic signed [31:0] variance_value;
   } table_req_type;

   // One response transaction: the interpolated point.
   typedef struct packed {
      logic [30:0] energy;
      logic [30:0] variance;
      logic        table_error;
   } point_type;

   // Settle time after the last response, beyond the slowest query.
   localparam int SETTLE_CYCLES = 120;
   // Long receiver hold-off, long enough to back the block up into its input.
   localparam int LONG_HOLD = 400;
   localparam longint OUT_MAX = 64'sd2147483647;
   localparam logic [67:0] QUOT_LIMIT = 68'd1 << QCAP_BIT;

   // Phase traffic shaping flags.
   localparam int MODE_GAPS   = 1;
   localparam int MODE_STALLS = 2;
   localparam int MODE_HOLD   = 4;
   localparam int MODE_WIDE   = 8;

   // Per-phase settings: active_entries written, ramp length reloaded,
   // random transactions, traffic mode. Out-of-range counts clamp in the block.
   int phase_active [9] = '{127, 2, 9, 0, 33, 1, 65, 64, 5};
   int phase_reload [9] = '{64, 2, 9, 0, 33, 2, 0, 64, 5};
   int phase_items  [9] = '{50, 40, 60, 30, 60, 30, 50, 50, 40};
   int phase_mode   [9] = '{MODE_GAPS | MODE_STALLS, 0, MODE_HOLD,
                            MODE_GAPS | MODE_STALLS, MODE_GAPS, MODE_STALLS,
                            MODE_GAPS | MODE_STALLS,
                            MODE_GAPS | MODE_STALLS | MODE_WIDE, 0};

   // Shadow of the block: breakpoint table and active_entries, updated on
   // accepted transactions and register writes.
   logic signed [31:0] tbl_wave   [TABLE_DEPTH];
   logic signed [31:0] tbl_energy [TABLE_DEPTH];
   logic signed [31:0] tbl_var    [TABLE_DEPTH];
   logic [6:0]         active_cfg = ACTIVE_RESET;

   // Generator's view of the wavenumbers it has planned, for aiming queries.
   logic signed [31:0] planned_wave [TABLE_DEPTH];

   table_req_type queued_requests [$];   // filled by the sequencer, drained by the driver
   point_type     expected_points [$];   // predicted responses, oldest first

   bit req_fire = 1'b0;               // request transaction taken at the last rising edge
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_requests = 0;
   int hold_served = 0;
   bit sender_gaps_on = 1'b0;
   bit stall_rsp_on = 1'b0;
   int error_count = 0;

   spectrum_table_interpolator_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_entry_index    (req_entry_index),
      .req_wavenumber     (req_wavenumber),
      .req_energy_value   (req_energy_value),
      .req_variance_value (req_variance_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_energy         (rsp_energy),
      .rsp_variance       (rsp_variance),
      .rsp_table_error    (rsp_table_error),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic log_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Line through (a, b) evaluated from pivot p: yp + (ya - yb) * dx / den,
   // quotient truncated toward zero and capped, result clamped to [0, 2^31-1].
   function automatic logic [30:0] line_eval(input longint ya, input longint yb,
                                             input longint yp, input longint dx,
                                             input longint den);
      longint      dy;
      longint      sum;
      logic        neg;
      logic [33:0] dy_mag;
      logic [33:0] dx_mag;
      logic [33:0] den_mag;
      logic [67:0] prod;
      logic [67:0] quo;
      dy = ya - yb;
      neg = ((dy < 0) != (dx < 0)) != (den < 0);
      dy_mag = 34'((dy < 0) ? -dy : dy);
      dx_mag = 34'((dx < 0) ? -dx : dx);
      den_mag = 34'((den < 0) ? -den : den);
      quo = '0;
      if (dy != 0 && dx != 0) begin
         prod = 68'(dy_mag) * 68'(dx_mag);
         quo = prod / 68'(den_mag);
         if (quo > QUOT_LIMIT) quo = QUOT_LIMIT;
      end
      sum = neg ? yp - longint'(quo[40:0]) : yp + longint'(quo[40:0]);
      if (sum < 0) sum = 0;
      if (sum > OUT_MAX) sum = OUT_MAX;
      return sum[30:0];
   endfunction

   // Expected response to a query at x against the shadow table.
   function automatic point_type interpolate_point(input logic signed [31:0] x);
      int        n;
      int        hit;
      int        j;
      int        a;
      int        b;
      int        p;
      longint    span;
      longint    dx;
      point_type pt;
      n = int'(active_cfg);
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      // first entry above x; scanning down leaves the lowest such index
      hit = n;
      for (j = n - 1; j >= 0; j--)
         if (x < tbl_wave[j]) hit = j;
      if (hit == n) begin
         // past the last entry: extrapolate the end segment
         a = n - 2;
         b = n - 1;
         p = b;
      end else if (hit == 0) begin
         // below the first interval: pivot on the first point
         a = 0;
         b = 1;
         p = 0;
      end else begin
         a = hit - 1;
         b = hit;
         p = hit;
      end
      pt = '0;
      span = longint'(tbl_wave[b]) - longint'(tbl_wave[a]);
      if (span == 0) begin
         // zero-width segment: flag only, values stay zero
         pt.table_error = 1'b1;
      end else begin
         dx = longint'(tbl_wave[p]) - longint'(x);
         pt.energy = line_eval(tbl_energy[a], tbl_energy[b], tbl_energy[p], dx, span);
         pt.variance = line_eval(tbl_var[a], tbl_var[b], tbl_var[p], dx, span);
      end
      return pt;
   endfunction

   // Monitor: samples both channels and the register port at the rising edge.
   always @(posedge clock) begin
      point_type want;
      req_fire = 1'b0;
      if (!reset) begin
         if (csr_wr_en) active_cfg = csr_wr_data;
         if (req_valid && !req_stall) begin
            req_fire = 1'b1;
            if (req_op == OP_LOAD) begin
               tbl_wave[req_entry_index] = req_wavenumber;
               tbl_energy[req_entry_index] = req_energy_value;
               tbl_var[req_entry_index] = req_variance_value;
            end else begin
               expected_points.push_back(interpolate_point(req_wavenumber));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               log_mismatch("response transaction with no query outstanding");
            end else begin
               want = expected_points.pop_front();
               if (rsp_energy !== want.energy)
                  log_mismatch($sformatf("energy got %h want %h", rsp_energy, want.energy));
               if (rsp_variance !== want.variance)
                  log_mismatch($sformatf("variance got %h want %h",
                                         rsp_variance, want.variance));
               if (rsp_table_error !== want.table_error)
                  log_mismatch($sformatf("table_error got %b want %b",
                                         rsp_table_error, want.table_error));
            end
         end
      end
   end

   // Driver: moves to the next queued request once the current one is taken,
   // with a random gap before the next when gaps are enabled.
   always @(negedge clock) begin
      logic          valid_next;
      table_req_type cur;
      int            r;
      valid_next = req_valid;
      if (reset) begin
         valid_next = 1'b0;
      end else if (!req_valid || req_fire) begin
         valid_next = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (queued_requests.size() != 0) begin
            cur = queued_requests.pop_front();
            req_op <= cur.op;
            req_entry_index <= cur.entry_index;
            req_wavenumber <= cur.wavenumber;
            req_energy_value <= cur.energy_value;
            req_variance_value <= cur.variance_value;
            valid_next = 1'b1;
            // mostly back to back, some short gaps, a few long ones
            r = $urandom_range(0, 99);
            if (!sender_gaps_on || r < 65) gap_left = 0;
            else if (r < 95) gap_left = $urandom_range(1, 4);
            else gap_left = $urandom_range(20, 80);
         end
      end
      req_valid <= valid_next;
   end

   // Receiver: random stalls, plus a long hold-off when the sequencer asks.
   always @(negedge clock) begin
      logic stall_next;
      int   r;
      stall_next = 1'b0;
      if (!reset) begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (stall_rsp_on) begin
            r = $urandom_range(0, 99);
            if (r >= 60) begin
               stall_next = 1'b1;
               stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
            end
         end
      end
      rsp_stall <= stall_next;
   end

   function automatic void push_load(input int idx, input logic signed [31:0] k,
                                     input logic signed [31:0] e,
                                     input logic signed [31:0] v);
      table_req_type t;
      t.op = OP_LOAD;
      t.entry_index = 6'(idx);
      t.wavenumber = k;
      t.energy_value = e;
      t.variance_value = v;
      planned_wave[idx[5:0]] = k;
      queued_requests.push_back(t);
   endfunction

   // Unused fields of a query carry random bits; the block must ignore them.
   function automatic void push_query(input logic signed [31:0] x);
      table_req_type t;
      t.op = OP_QUERY;
      t.entry_index = 6'($urandom);
      t.wavenumber = x;
      t.energy_value = $urandom;
      t.variance_value = $urandom;
      queued_requests.push_back(t);
   endfunction

   // Breakpoint sample: mostly small signed, some large positive, some raw.
   function automatic logic signed [31:0] rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      if (r < 85) return $urandom_range(0, 32'h1000_0000);
      return $urandom;
   endfunction

   // Query point: mostly inside the active span (with some overshoot on both
   // ends), some exact breakpoints and near misses, some anywhere.
   function automatic logic signed [31:0] pick_query_x(input int n);
      longint lo;
      longint hi;
      longint margin;
      longint xl;
      int     j;
      int     r;
      lo = planned_wave[0];
      hi = planned_wave[0];
      for (j = 1; j < n; j++) begin
         if (planned_wave[j] < lo) lo = planned_wave[j];
         if (planned_wave[j] > hi) hi = planned_wave[j];
      end
      margin = (hi - lo) / 4 + 16;
      r = $urandom_range(0, 99);
      j = $urandom_range(0, n - 1);
      if (r < 70)
         xl = lo - margin + longint'({$urandom, $urandom} % 64'(hi - lo + 2 * margin + 1));
      else if (r < 80)
         xl = planned_wave[j];
      else if (r < 88)
         xl = longint'(planned_wave[j]) + (($urandom_range(0, 1) != 0) ? 1 : -1);
      else
         return $urandom;
      if (xl > 64'sd2147483647) xl = 64'sd2147483647;
      if (xl < -64'sd2147483648) xl = -64'sd2147483648;
      return xl[31:0];
   endfunction

   // Wait for the block to go quiet: everything sent, every response back,
   // then a settle time for any load or query still in flight.
   task automatic drain();
      while (queued_requests.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Called at a falling edge with the block idle.
   task automatic write_active(input logic [6:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sequencer: directed transactions, then phases of random traffic under
   // different active_entries settings and traffic shapes.
   initial begin
      int ph;
      int j;
      int r;
      int n_eff;
      int base;
      int stepv;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a two-entry table, exercised on every side of the segment.
      write_active(7'd2);
      @(posedge clock);
      push_load(0, 32'sh0000_0000, 32'sh000A_0000, 32'sh0002_0000);
      push_load(1, 32'sh0001_0000, 32'sh0014_0000, 32'sh0001_0000);
      push_query(32'sh0000_8000);              // inside the segment
      push_query(32'sh0000_0000);              // exactly on the first point
      push_query(32'shFFFF_0000);              // below the table, energy hits zero
      push_query(32'sh8000_0000);              // most negative query point
      push_query(32'sh7FFF_FFFF);              // past the end, saturates
      push_load(63, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      push_load(62, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      // equal neighbors: error from above and from below
      push_load(1, 32'sh0000_0000, 32'sh0014_0000, 32'sh0001_0000);
      push_query(32'sh0000_0005);
      push_query(32'shFFFF_FFFB);
      // unsorted pair: negative segment width
      push_load(1, 32'shFFFF_0000, 32'sh0003_0000, 32'sh001E_0000);
      push_query(32'sh0000_8000);
      push_query(32'shFFFE_0000);
      // full-scale values one LSB apart: quotient hits its cap
      push_load(0, 32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      push_load(1, 32'sh0000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF);
      push_query(32'sh7FFF_FFFF);
      push_query(32'sh8000_0000);
      push_query(32'sh0000_0001);              // on the last point, zero offset
      push_query(32'sh0000_0000);

      for (ph = 0; ph < 9; ph++) begin
         drain();
         write_active(phase_active[ph][6:0]);
         @(posedge clock);
         sender_gaps_on = (phase_mode[ph] & MODE_GAPS) != 0;
         stall_rsp_on = (phase_mode[ph] & MODE_STALLS) != 0;
         // receiver holds off while the sender keeps pushing queries
         if ((phase_mode[ph] & MODE_HOLD) != 0) hold_requests++;
         n_eff = phase_active[ph];
         if (n_eff < 2) n_eff = 2;
         if (n_eff > TABLE_DEPTH) n_eff = TABLE_DEPTH;

         // fresh ramp: mostly rising, a few flat or falling steps
         base = int'($urandom_range(0, 32'h0100_0000)) - 8388608;
         for (j = 0; j < phase_reload[ph]; j++) begin
            push_load(j, base, rand_sample(), rand_sample());
            r = $urandom_range(0, 99);
            if (r < 6) stepv = 0;
            else if (r < 10) stepv = -int'($urandom_range(1, 32'h0001_0000));
            else if ((phase_mode[ph] & MODE_WIDE) != 0)
               stepv = int'($urandom_range(1, 32'h0100_0000));
            else stepv = int'($urandom_range(1, 32'h0010_0000));
            base += stepv;
         end

         // mostly queries; some value rewrites in place, some raw loads
         for (j = 0; j < phase_items[ph]; j++) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
               stepv = $urandom_range(0, n_eff - 1);
               push_load(stepv, planned_wave[stepv], rand_sample(), rand_sample());
            end else if (r < 12) begin
               push_load($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom, $urandom);
            end else begin
               push_query(pick_query_x(n_eff));
            end
         end
      end

      drain();
      if (error_count == 0) begin
         $display("spectrum_table_interpolator_top verification clean");
      end else begin
         $display("spectrum_table_interpolator_top verification failed");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #8_000_000;
      $display("spectrum_table_interpolator_top verification failed");
      $finish;
   end

endmodule
